/* rtl/core/ccs_pkg.sv */
// Shared types, constants and scramble functions for the console ID scramble codec.
package ccs_pkg;

  localparam int unsigned NumW = 53;
  localparam int unsigned RemW = 10;

  localparam logic        MODE_BUILD  = 1'b0;
  localparam logic        MODE_DECODE = 1'b1;

  localparam logic [10:0]     POLY    = 11'h635;
  localparam logic [NumW-1:0] MASK_B3 = 53'h0000_B3B3_B3B3_B3B3;
  localparam logic [NumW-1:0] MASK_5E = 53'h0000_5E5E_5E5E_5E5E;

  localparam logic [2:0] PERM     [6]  = '{3'd1, 3'd5, 3'd0, 3'd4, 3'd2, 3'd3};
  localparam logic [3:0] SBOX     [16] = '{4'h4, 4'hB, 4'h7, 4'h9, 4'hF, 4'h1, 4'hD, 4'h3,
                                           4'hC, 4'h2, 4'h6, 4'hE, 4'h8, 4'h0, 4'hA, 4'h5};
  localparam logic [3:0] SBOX_INV [16] = '{4'hD, 4'h5, 4'h9, 4'h7, 4'h0, 4'hF, 4'hA, 4'h2,
                                           4'hC, 4'h3, 4'hE, 4'h1, 4'h8, 4'h6, 4'hB, 4'h4};

  typedef logic [NumW-1:0][RemW-1:0] rem_tbl_t;

  typedef struct packed {
    logic            mode;
    logic [NumW-1:0] val;
  } ccs_word_t;

  typedef struct packed {
    logic [NumW-1:0] number;
    logic [31:0]     chip_id;
    logic [4:0]      counter;
    logic [2:0]      model;
    logic [2:0]      region;
    logic [RemW-1:0] stored_check;
    logic [RemW-1:0] remainder;
    logic            ok;
  } ccs_result_t;

  // Each entry is the remainder of a single set bit, so the remainder of a word
  // is the XOR of the entries of its set bits.
  function automatic rem_tbl_t gen_rem_tbl();
    rem_tbl_t        tbl;
    logic [NumW-1:0] v;
    for (int b = 0; b < NumW; b++) begin
      v = NumW'(1) << b;
      for (int j = NumW - 1; j >= RemW; j--) begin
        if (v[j]) begin
          v = v ^ (NumW'(POLY) << (j - RemW));
        end
      end
      tbl[b] = v[RemW-1:0];
    end
    return tbl;
  endfunction

  localparam rem_tbl_t REM_TBL = gen_rem_tbl();

  function automatic logic [RemW-1:0] rem53(logic [NumW-1:0] v);
    logic [RemW-1:0] r;
    r = '0;
    for (int b = 0; b < NumW; b++) begin
      if (v[b]) begin
        r = r ^ REM_TBL[b];
      end
    end
    return r;
  endfunction

  function automatic logic [NumW-1:0] rotl53(logic [NumW-1:0] v, int unsigned n);
    logic [2*NumW-1:0] t;
    t = {v, v} << n;
    return t[2*NumW-1:NumW];
  endfunction

  function automatic logic [NumW-1:0] subst6(logic [NumW-1:0] v, logic inv);
    logic [NumW-1:0] r;
    r = v;
    for (int k = 0; k < 6; k++) begin
      if (inv) begin
        r[8*k+4 +: 4] = SBOX_INV[v[8*k+4 +: 4]];
        r[8*k +: 4]   = SBOX_INV[v[8*k +: 4]];
      end else begin
        r[8*k+4 +: 4] = SBOX[v[8*k+4 +: 4]];
        r[8*k +: 4]   = SBOX[v[8*k +: 4]];
      end
    end
    return r;
  endfunction

  function automatic logic [NumW-1:0] perm6(logic [NumW-1:0] v, logic inv);
    logic [NumW-1:0] r;
    r = v;
    for (int k = 0; k < 6; k++) begin
      if (inv) begin
        r[8*k +: 8] = v[8*PERM[k] +: 8];
      end else begin
        r[8*PERM[k] +: 8] = v[8*k +: 8];
      end
    end
    return r;
  endfunction

endpackage

/* rtl/core/console_id_scramble_codec.sv */
// Top level of the console ID scramble codec: three pipeline stages.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid_i / in_ready_o  mode, chip_id, id_counter, model_code,
//                                                region_code, user_number
//   out      output     out_valid_o / out_ready_i number, fields, check, remainder, ok
//
// One transfer is accepted per cycle while the output is not stalled; every item passes
// through the three registered stages of the scramble network from input to output.
// Reset clears only the stage valid bits.
// Each stage holds its item while the next one stalls and refills as soon as it
// empties, so a stall loses and repeats no transfer.
module console_id_scramble_codec (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      mode_i,
  input  logic [31:0]               chip_id_i,
  input  logic [4:0]                id_counter_i,
  input  logic [2:0]                model_code_i,
  input  logic [2:0]                region_code_i,
  input  logic [ccs_pkg::NumW-1:0]  user_number_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [ccs_pkg::NumW-1:0]  number_out_o,
  output logic [31:0]               chip_id_out_o,
  output logic [4:0]                counter_out_o,
  output logic [2:0]                model_out_o,
  output logic [2:0]                region_out_o,
  output logic [ccs_pkg::RemW-1:0]  stored_check_o,
  output logic [ccs_pkg::RemW-1:0]  check_remainder_o,
  output logic                      check_ok_o
);
  import ccs_pkg::*;

  logic        s1_valid, s1_ready;
  logic        s2_valid, s2_ready;
  ccs_word_t   s1_word, s2_word;
  ccs_result_t res;

  ccs_front u_front (
    .clk_i,
    .rst_ni,
    .valid_i       (in_valid_i),
    .ready_o       (in_ready_o),
    .mode_i,
    .chip_id_i,
    .id_counter_i,
    .model_code_i,
    .region_code_i,
    .user_number_i,
    .valid_o       (s1_valid),
    .ready_i       (s1_ready),
    .word_o        (s1_word)
  );

  ccs_mid u_mid (
    .clk_i,
    .rst_ni,
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .word_i  (s1_word),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .word_o  (s2_word)
  );

  ccs_back u_back (
    .clk_i,
    .rst_ni,
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .word_i  (s2_word),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (res)
  );

  assign number_out_o      = res.number;
  assign chip_id_out_o     = res.chip_id;
  assign counter_out_o     = res.counter;
  assign model_out_o       = res.model;
  assign region_out_o      = res.region;
  assign stored_check_o    = res.stored_check;
  assign check_remainder_o = res.remainder;
  assign check_ok_o        = res.ok;

endmodule

/* rtl/core/ccs_front.sv */
// First stage: packs and appends the check when building, undoes the outer layers when decoding.
module ccs_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic                      mode_i,
  input  logic [31:0]               chip_id_i,
  input  logic [4:0]                id_counter_i,
  input  logic [2:0]                model_code_i,
  input  logic [2:0]                region_code_i,
  input  logic [ccs_pkg::NumW-1:0]  user_number_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output ccs_pkg::ccs_word_t        word_o
);
  import ccs_pkg::*;

  logic            valid_q;
  ccs_word_t       word_d, word_q;
  logic [NumW-1:0] plain;
  logic [NumW-1:0] dec;

  always_comb begin
    plain = {region_code_i, model_code_i, chip_id_i, id_counter_i, {RemW{1'b0}}};
    plain[RemW-1:0] = rem53(plain);
    dec = subst6(perm6(rotl53(user_number_i ^ MASK_5E, 52), 1'b1), 1'b1);
    word_d.mode = mode_i;
    word_d.val  = (mode_i == MODE_DECODE) ? dec : plain;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

/* rtl/core/ccs_mid.sv */
// Second stage: mask, rotate, substitute and permute when building; rotate and unmask when decoding.
module ccs_mid (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  ccs_pkg::ccs_word_t  word_i,
  output logic                valid_o,
  input  logic                ready_i,
  output ccs_pkg::ccs_word_t  word_o
);
  import ccs_pkg::*;

  logic      valid_q;
  ccs_word_t word_d, word_q;

  always_comb begin
    word_d.mode = word_i.mode;
    if (word_i.mode == MODE_DECODE) begin
      word_d.val = rotl53(word_i.val, 10) ^ MASK_B3;
    end else begin
      word_d.val = perm6(subst6(rotl53(word_i.val ^ MASK_B3, 43), 1'b0), 1'b0);
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

/* rtl/core/ccs_back.sv */
// Last stage: final rotate and mask when building; field split and check when decoding.
module ccs_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  ccs_pkg::ccs_word_t   word_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output ccs_pkg::ccs_result_t res_o
);
  import ccs_pkg::*;

  logic            valid_q;
  ccs_result_t     res_d, res_q;
  logic [RemW-1:0] rem;

  always_comb begin
    rem   = rem53(word_i.val);
    res_d = '0;
    if (word_i.mode == MODE_DECODE) begin
      res_d.number       = word_i.val;
      res_d.chip_id      = word_i.val[46:15];
      res_d.counter      = word_i.val[14:10];
      res_d.model        = word_i.val[49:47];
      res_d.region       = word_i.val[52:50];
      res_d.stored_check = word_i.val[RemW-1:0];
      res_d.remainder    = rem;
      res_d.ok           = (rem[7:0] == 8'h00);
    end else begin
      res_d.number = rotl53(word_i.val, 1) ^ MASK_5E;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
